>>> hdl/cmf_pkg.sv
// types, constants and the crc-16/xmodem byte update for the message fragmenter
// no dependencies
package cmf_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MTU_BYTES         = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MESSAGE_BYTES = 1'd1;

   localparam logic [15:0] MTU_RESET         = 16'd1472;
   localparam logic [15:0] MAX_MESSAGE_RESET = 16'd8192;
   localparam logic [15:0] MTU_FLOOR         = 16'd2;
   localparam logic [15:0] CRC_POLY          = 16'h1021;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_message;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       end_marker;
      logic       too_long;
      logic       run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_FINAL,
      CMD_ERROR
   } cmd_kind_type;

   // one queued job: a plain byte, a final byte with its crc trailer, or an error
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic         packet_end;
      logic [15:0]  crc;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_FIRST,
      BACK_CRC_HI,
      BACK_CRC_LO,
      BACK_MARKER
   } back_state_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/cmf_front.sv
// front end: takes message words, keeps crc, fill and length, queues jobs
// depends on cmf_pkg
module cmf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cmf_pkg::req_type         req_data,
   input  logic [15:0]              mtu_bytes,
   input  logic [15:0]              max_message_bytes,
   input  cmf_pkg::queue_status_type q_status,
   output logic                     push,
   output cmf_pkg::cmd_type         push_cmd
);
   import cmf_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [15:0] fill_ff, fill_in;
   logic [15:0] length_ff, length_in;
   logic        overflowed_ff, overflowed_in;

   logic        accept;
   logic [15:0] mtu_eff;
   logic [15:0] crc_next;
   logic [15:0] fill_next;
   logic        too_long;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign mtu_eff   = (mtu_bytes < MTU_FLOOR) ? MTU_FLOOR : mtu_bytes;
   assign crc_next  = crc16_update(crc_ff, req_data.data_byte);
   assign fill_next = fill_ff + 16'd1;
   assign too_long  = ({1'b0, length_ff} + 17'd1) > {1'b0, max_message_bytes};

   always_comb begin
      crc_in        = crc_ff;
      fill_in       = fill_ff;
      length_in     = length_ff;
      overflowed_in = overflowed_ff;
      push          = 1'b0;
      push_cmd.kind       = CMD_BYTE;
      push_cmd.data_byte  = req_data.data_byte;
      push_cmd.packet_end = 1'b0;
      push_cmd.crc        = crc_next;
      if (accept && !req_data.empty_message) begin
         if (overflowed_ff) begin
            // abandoned message: drop words until its last one
            if (req_data.last_byte) begin
               overflowed_in = 1'b0;
               crc_in        = '0;
               fill_in       = '0;
               length_in     = '0;
            end
         end else if (too_long) begin
            push          = 1'b1;
            push_cmd.kind = CMD_ERROR;
            if (req_data.last_byte) begin
               crc_in    = '0;
               fill_in   = '0;
               length_in = '0;
            end else begin
               overflowed_in = 1'b1;
            end
         end else if (!req_data.last_byte) begin
            push                = 1'b1;
            push_cmd.kind       = CMD_BYTE;
            push_cmd.packet_end = (fill_next >= mtu_eff);
            crc_in              = crc_next;
            length_in           = length_ff + 16'd1;
            fill_in             = (fill_next >= mtu_eff) ? 16'd0 : fill_next;
         end else begin
            // crc bytes fit in this datagram only if two more bytes still fit
            push                = 1'b1;
            push_cmd.kind       = CMD_FINAL;
            push_cmd.packet_end = ({1'b0, fill_next} + 17'd2) > {1'b0, mtu_eff};
            crc_in              = '0;
            fill_in             = '0;
            length_in           = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= '0;
         fill_ff       <= '0;
         length_ff     <= '0;
         overflowed_ff <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         fill_ff       <= fill_in;
         length_ff     <= length_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

>>> hdl/cmf_cmd_fifo.sv
// small job queue between front and back ends
// depends on cmf_pkg
module cmf_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cmf_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output cmf_pkg::cmd_type          head_cmd,
   output cmf_pkg::queue_status_type status
);
   import cmf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hdl/cmf_back.sv
// back end: expands queued jobs into result words through an output register
// depends on cmf_pkg
module cmf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cmf_pkg::queue_status_type q_status,
   input  cmf_pkg::cmd_type          head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cmf_pkg::rsp_type          rsp_data
);
   import cmf_pkg::*;

   back_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           advance;

   assign advance   = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         case (state_ff)
            BACK_FIRST:  state_in = (head_cmd.kind == CMD_FINAL) ? BACK_CRC_HI : BACK_FIRST;
            BACK_CRC_HI: state_in = BACK_CRC_LO;
            BACK_CRC_LO: state_in = BACK_MARKER;
            BACK_MARKER: state_in = BACK_FIRST;
            default:     state_in = BACK_FIRST;
         endcase
      end
   end

   // outputs
   always_comb begin
      rsp_data_in = '0;
      pop         = 1'b0;
      case (state_ff)
         BACK_FIRST: begin
            if (head_cmd.kind == CMD_ERROR) begin
               rsp_data_in.too_long = 1'b1;
               rsp_data_in.run_last = 1'b1;
               pop                  = advance;
            end else begin
               rsp_data_in.out_byte   = head_cmd.data_byte;
               rsp_data_in.packet_end = head_cmd.packet_end;
               rsp_data_in.run_last   = (head_cmd.kind != CMD_FINAL);
               pop                    = advance && (head_cmd.kind != CMD_FINAL);
            end
         end
         BACK_CRC_HI: begin
            rsp_data_in.out_byte = head_cmd.crc[15:8];
         end
         BACK_CRC_LO: begin
            rsp_data_in.out_byte   = head_cmd.crc[7:0];
            rsp_data_in.packet_end = 1'b1;
         end
         BACK_MARKER: begin
            rsp_data_in.end_marker = 1'b1;
            rsp_data_in.run_last   = 1'b1;
            pop                    = advance;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hdl/crc_message_fragmenter.sv
// top level of the crc-16/xmodem message fragmenter
// depends on cmf_pkg, cmf_front, cmf_cmd_fifo and cmf_back
//
//  channel  ports                         direction  carries
//  req      req_valid/req_ready/req_data  in         one message byte per word
//  rsp      rsp_valid/rsp_ready/rsp_data  out        one datagram byte, marker or error
//  csr      csr_write/csr_index/csr_wdata in         mtu and message limit writes
//
// req and rsp each run a word per cycle, unless the queue is full or rsp is not ready
// the last byte of a message gives four rsp words (byte, crc high, crc low, end marker),
// and the back end pops that job only with the marker, while the front end keeps queueing
// an accepted word reaches rsp via the queue write, then the output register
// req_ready drops only when the job queue is full; rsp stalls back up through the queue
// synchronous active-high reset clears message state and loads mtu 1472, limit 8192
module crc_message_fragmenter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cmf_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cmf_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [cmf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cmf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cmf_pkg::*;

   // configuration registers
   logic [15:0] mtu_ff, mtu_in;
   logic [15:0] max_msg_ff, max_msg_in;

   // queue hookup
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head_cmd;
   queue_status_type q_status;

   always_comb begin
      mtu_in     = mtu_ff;
      max_msg_in = max_msg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MTU_BYTES:         mtu_in     = csr_wdata;
            CSR_MAX_MESSAGE_BYTES: max_msg_in = csr_wdata;
            default:               mtu_in     = mtu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff     <= MTU_RESET;
         max_msg_ff <= MAX_MESSAGE_RESET;
      end else begin
         mtu_ff     <= mtu_in;
         max_msg_ff <= max_msg_in;
      end
   end

   // front end: crc, datagram fill, length limit, job classification
   cmf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .mtu_bytes         (mtu_ff),
      .max_message_bytes (max_msg_ff),
      .q_status          (q_status),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // decouples the byte-per-cycle front from the multi-word trailer in the back
   cmf_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // back end: one rsp word per cycle from the head job when not stalled
   cmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/crc_message_fragmenter_tb.sv
// self-checking testbench for crc_message_fragmenter: byte stream in, datagram words out
// depends on cmf_pkg and the crc_message_fragmenter rtl
// a local fragmenter model predicts every rsp word; random stalls on both channels
module crc_message_fragmenter_tb;
   import cmf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_WORDS = 42;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MTU_BYTES;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // stimulus waiting for the driver and datagram words still owed by the block
   req_type pending_bytes[$];
   rsp_type due_words[$];
   rsp_type head_word;
   int      queued_count = 0;
   int      accepted_count = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 27;
   int      recv_idle_pct = 76;

   // model copy of the registers and of the per-message state
   logic [15:0] cfg_mtu = MTU_RESET;
   logic [15:0] cfg_max_len = MAX_MESSAGE_RESET;
   logic [15:0] crc_acc = '0;
   logic [16:0] fill_count = '0;
   logic [15:0] msg_count = '0;
   logic        abandoned = 1'b0;

   crc_message_fragmenter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // crc-16/xmodem, one message bit at a time, msb first
   function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] c;
      logic        feedback;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[15] ^ data[i];
         c = {c[14:0], 1'b0};
         if (feedback) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void owe_word(input logic [7:0] data, input logic pend,
                                    input logic mark, input logic err, input logic last);
      rsp_type w;
      w.out_byte   = data;
      w.packet_end = pend;
      w.end_marker = mark;
      w.too_long   = err;
      w.run_last   = last;
      due_words = {due_words, w};
   endfunction

   function automatic void clear_message();
      crc_acc    = '0;
      fill_count = '0;
      msg_count  = '0;
      abandoned  = 1'b0;
   endfunction

   // works out the datagram words that one accepted req word causes
   function automatic void fragment_word(input req_type w);
      logic [16:0] mtu_eff;
      mtu_eff = (cfg_mtu < MTU_FLOOR) ? {1'b0, MTU_FLOOR} : {1'b0, cfg_mtu};
      // an empty message changes nothing, even inside a message
      if (w.empty_message) begin
         return;
      end
      // abandoned message: drop bytes until its last one, then start clean
      if (abandoned) begin
         if (w.last_byte) begin
            clear_message();
         end
         return;
      end
      // the byte that would pass the limit gives the single error word
      if ({1'b0, msg_count} + 17'd1 > {1'b0, cfg_max_len}) begin
         owe_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
         if (w.last_byte) begin
            clear_message();
         end else begin
            abandoned = 1'b1;
         end
         return;
      end
      msg_count  = msg_count + 16'd1;
      crc_acc    = crc_xmodem_step(crc_acc, w.data_byte);
      fill_count = fill_count + 17'd1;
      if (!w.last_byte) begin
         // datagram closes once the fill reaches the mtu, also after the mtu was lowered
         if (fill_count >= mtu_eff) begin
            owe_word(w.data_byte, 1'b1, 1'b0, 1'b0, 1'b1);
            fill_count = '0;
         end else begin
            owe_word(w.data_byte, 1'b0, 1'b0, 1'b0, 1'b1);
         end
         return;
      end
      // last byte: crc joins this datagram only if both bytes fit
      owe_word(w.data_byte, (fill_count + 17'd2 > mtu_eff), 1'b0, 1'b0, 1'b0);
      owe_word(crc_acc[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
      owe_word(crc_acc[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
      owe_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
      clear_message();
   endfunction

   // driver: holds a word until accepted, predicts at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            fragment_word(req_data);
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: every accepted rsp word must match the oldest owed word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               $display("%0t: unexpected rsp word %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               head_word = due_words.pop_front();
               if (rsp_data !== head_word) begin
                  // fields: byte, packet end, end marker, too long, run last
                  $display("%0t: rsp mismatch exp %h %b %b %b %b got %h %b %b %b %b",
                           $time, head_word.out_byte, head_word.packet_end,
                           head_word.end_marker, head_word.too_long,
                           head_word.run_last, rsp_data.out_byte,
                           rsp_data.packet_end, rsp_data.end_marker,
                           rsp_data.too_long, rsp_data.run_last);
                  error_count <= error_count + 1;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words owed", $time, due_words.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_word(input logic [7:0] data, input logic last, input logic empty);
      req_type w;
      w.data_byte     = data;
      w.last_byte     = last;
      w.empty_message = empty;
      pending_bytes = {pending_bytes, w};
      queued_count++;
   endtask

   // all words sent and answered, then a drain wait for words that cause nothing
   task automatic settle();
      while (accepted_count != queued_count || due_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_MTU_BYTES) begin
         cfg_mtu = value;
      end else begin
         cfg_max_len = value;
      end
   endtask

   task automatic apply_settings(input logic [15:0] mtu, input logic [15:0] max_len);
      write_csr(CSR_MTU_BYTES, mtu);
      write_csr(CSR_MAX_MESSAGE_BYTES, max_len);
      csr_write <= 1'b0;
   endtask

   // mostly small datagrams, now and then the floor or the top of the range
   function automatic logic [15:0] pick_mtu();
      case ($urandom_range(9))
         0: return 16'($urandom_range(2));
         1: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'd65507;
         2: return MTU_RESET;
         default: return 16'($urandom_range(24, 2));
      endcase
   endfunction

   // mostly roomy, sometimes tight enough to abandon messages
   function automatic logic [15:0] pick_limit();
      case ($urandom_range(9))
         0: return 16'd0;
         1, 2: return 16'($urandom_range(8, 1));
         3: return 16'hFFFF;
         default: return 16'($urandom_range(120, 20));
      endcase
   endfunction

   initial begin
      int n;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty message, a one-byte and a two-byte message, then leave a message open
      queue_word(8'hAA, 1'b1, 1'b1);
      queue_word(8'hFF, 1'b1, 1'b0);
      queue_word(8'h00, 1'b0, 1'b0);
      queue_word(8'h5A, 1'b1, 1'b0);
      for (int i = 0; i < 5; i++) begin
         queue_word(8'h31 + 8'(i), 1'b0, 1'b0);
      end
      settle();

      // mtu lowered under the open fill closes on the next byte; crc fits exactly
      apply_settings(16'd3, 16'hFFFF);
      queue_word(8'h36, 1'b0, 1'b0);
      queue_word(8'h37, 1'b1, 1'b0);
      queue_word(8'hC3, 1'b1, 1'b0);
      settle();

      // mtu 0 acts as 2: crc gets its own datagram; limit 3 abandons longer messages
      apply_settings(16'd0, 16'd3);
      queue_word(8'h01, 1'b0, 1'b0);
      queue_word(8'h02, 1'b0, 1'b0);
      queue_word(8'h03, 1'b1, 1'b0);
      queue_word(8'h10, 1'b0, 1'b0);
      queue_word(8'h11, 1'b0, 1'b0);
      queue_word(8'h7E, 1'b0, 1'b1);
      queue_word(8'h12, 1'b0, 1'b0);
      queue_word(8'h13, 1'b0, 1'b0);
      queue_word(8'h14, 1'b1, 1'b0);
      queue_word(8'h20, 1'b0, 1'b0);
      queue_word(8'h21, 1'b0, 1'b0);
      queue_word(8'h22, 1'b0, 1'b0);
      queue_word(8'h23, 1'b1, 1'b0);
      settle();

      // zero limit: every first byte is too long
      apply_settings(16'd1, 16'd0);
      queue_word(8'h44, 1'b0, 1'b0);
      queue_word(8'h45, 1'b1, 1'b0);
      queue_word(8'h46, 1'b1, 1'b0);
      settle();

      apply_settings(16'hFFFF, 16'hFFFF);
      queue_word(8'hFF, 1'b0, 1'b0);
      queue_word(8'h00, 1'b1, 1'b0);
      settle();

      // random messages; idle pattern changes every three phases
      for (int p = 0; p < 9; p++) begin
         send_idle_pct = (p < 3) ? 27 : (p < 6) ? 76 : 0;
         recv_idle_pct = (p < 3) ? 76 : (p < 6) ? 27 : 0;
         apply_settings(pick_mtu(), pick_limit());
         n = 0;
         while (n < PHASE_WORDS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(90, 25) : $urandom_range(24, 1);
            for (int k = 0; k < len; k++) begin
               // occasional empty message in the stream, with junk in the other fields
               if ($urandom_range(19) == 0) begin
                  queue_word(8'($urandom), 1'($urandom), 1'b1);
               end
               queue_word(8'($urandom_range(255)), (k == len - 1), 1'b0);
               n++;
               // sometimes stop mid-message so the next settings land on an open one
               if (n >= PHASE_WORDS && $urandom_range(3) == 0) begin
                  break;
               end
            end
         end
         settle();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
